### hw/rtl/sact_pkg.sv
// shared types, constants and helpers of the set-associative lru cache tracker
`default_nettype none
package sact_pkg;

  localparam int ADDR_WIDTH   = 64;
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W     = MAX_SET_BITS;
  localparam int SETCNT_W  = $clog2(MAX_SET_BITS + 1);
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W    = WAY_W;
  localparam int WAYCNT_W  = $clog2(MAX_WAYS + 1);
  // block offset is at least one bit, so the tag never needs the full address
  localparam int TAG_W     = ADDR_WIDTH - 1;
  localparam int SHIFT_W   = 6;

  // register widths
  localparam int SETB_W    = 3;
  localparam int BLKB_W    = 5;
  localparam int WAYS_W    = 4;
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 32;
  localparam int OP_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  typedef struct packed {
    logic hit;
    logic evicted;
  } lk_res_t;

  function automatic logic [RANK_W-1:0] rank_inc(input logic [RANK_W-1:0] r);
    if (int'(r) >= MAX_WAYS - 1) begin
      return RANK_W'(MAX_WAYS - 1);
    end
    return r + RANK_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sact_row_mem.sv
// set row memory: one row per set holding every way, with per-row valid flags
`default_nettype none
module sact_row_mem (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          rd_en,
  input  wire [sact_pkg::SET_W-1:0]    rd_addr,
  output sact_pkg::row_t               rd_row,
  input  wire                          wr_en,
  input  wire [sact_pkg::SET_W-1:0]    wr_addr,
  input  sact_pkg::row_t               wr_row
);

  sact_pkg::row_t                         mem [sact_pkg::NUM_SETS];
  logic [sact_pkg::NUM_SETS-1:0]          row_vld_r;
  sact_pkg::row_t                         rd_data_r;
  logic                                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  // a row never written reads as all ways empty with rank zero
  always_comb begin
    rd_row = rd_data_r;
    if (!rd_vld_r) begin
      for (int i = 0; i < sact_pkg::MAX_WAYS; i++) begin
        rd_row[i].valid = 1'b0;
        rd_row[i].rank  = '0;
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sact_lookup.sv
// tag compare, lru update and victim choice over one set row
`default_nettype none
module sact_lookup (
  input  sact_pkg::row_t                    row_in,
  input  wire [sact_pkg::TAG_W-1:0]         tag,
  input  wire [sact_pkg::WAYCNT_W-1:0]      ways,
  output sact_pkg::row_t                    row_out,
  output sact_pkg::lk_res_t                 res
);

  always_comb begin
    logic [sact_pkg::MAX_WAYS-1:0] used;
    logic                          hit;
    logic                          has_inv;
    logic [sact_pkg::WAY_W-1:0]    hw;
    logic [sact_pkg::WAY_W-1:0]    fw;
    logic [sact_pkg::WAY_W-1:0]    vw;
    logic [sact_pkg::WAY_W-1:0]    tw;
    logic [sact_pkg::RANK_W-1:0]   best_rank;
    logic [sact_pkg::RANK_W-1:0]   limit;

    for (int i = 0; i < sact_pkg::MAX_WAYS; i++) begin
      used[i] = sact_pkg::WAYCNT_W'(i) < ways;
    end

    hit     = 1'b0;
    hw      = '0;
    has_inv = 1'b0;
    fw      = '0;
    for (int i = 0; i < sact_pkg::MAX_WAYS; i++) begin
      if (!hit && used[i] && row_in[i].valid && row_in[i].tag == tag) begin
        hit = 1'b1;
        hw  = sact_pkg::WAY_W'(i);
      end
      if (!has_inv && used[i] && !row_in[i].valid) begin
        has_inv = 1'b1;
        fw      = sact_pkg::WAY_W'(i);
      end
    end

    // oldest used way, lowest number on a tie
    vw        = '0;
    best_rank = row_in[0].rank;
    for (int i = 1; i < sact_pkg::MAX_WAYS; i++) begin
      if (used[i] && row_in[i].rank > best_rank) begin
        vw        = sact_pkg::WAY_W'(i);
        best_rank = row_in[i].rank;
      end
    end

    tw    = hit ? hw : (has_inv ? fw : vw);
    limit = row_in[hw].rank;

    row_out = row_in;
    for (int i = 0; i < sact_pkg::MAX_WAYS; i++) begin
      if (sact_pkg::WAY_W'(i) != tw && used[i] && row_in[i].valid &&
          (!hit || row_in[i].rank < limit)) begin
        row_out[i].rank = sact_pkg::rank_inc(row_in[i].rank);
      end
    end
    row_out[tw].rank = '0;
    if (!hit) begin
      row_out[tw].valid = 1'b1;
      row_out[tw].tag   = tag;
    end

    res.hit     = hit;
    res.evicted = !hit && !has_inv;
  end

endmodule
`default_nettype wire

### hw/rtl/set_assoc_lru_cache_tracker.sv
// top level of the set-associative lru cache tracker
`default_nettype none
// Tracks the tag store of a set-associative cache with true lru replacement
// and reports hit, eviction and running totals for every lookup. Each set is
// one row of a synchronous ram (all ways side by side), so a lookup is a read
// of the row followed by an evaluate-and-write-back step: a load or store
// gives one result and a modify gives two; the next input beat is taken in the
// cycle after the last result is registered, so the block holds one access at
// a time. The second lookup of a modify works on the row it just wrote, held in
// a forwarding register. Rows carry a valid flag that reset clears at once, so
// the block is ready right after reset with no clearing pass. An op of 3 is
// taken and dropped. Results wait in an output register, which stalls
// evaluation only while it is full.
module set_assoc_lru_cache_tracker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire [sact_pkg::OP_W-1:0]           in_op,
  input  wire [sact_pkg::ADDR_WIDTH-1:0]     in_address,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               out_hit,
  output logic                               out_evicted,
  output logic                               out_last,
  output logic [sact_pkg::CNT_W-1:0]         out_hit_count,
  output logic [sact_pkg::CNT_W-1:0]         out_miss_count,
  output logic [sact_pkg::CNT_W-1:0]         out_eviction_count,
  input  wire                                cfg_we,
  input  wire [sact_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [sact_pkg::CFG_W-1:0]          cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t                              state_r, state_nxt;
  logic [sact_pkg::SETB_W-1:0]         set_bits_r;
  logic [sact_pkg::BLKB_W-1:0]         block_bits_r;
  logic [sact_pkg::WAYS_W-1:0]         ways_used_r;

  logic [sact_pkg::SETCNT_W-1:0]       set_eff;
  logic [sact_pkg::BLKB_W-1:0]         blk_eff;
  logic [sact_pkg::WAYCNT_W-1:0]       ways_eff;
  logic [sact_pkg::SET_W-1:0]          set_mask;
  logic [sact_pkg::SHIFT_W-1:0]        tag_sh;
  logic [sact_pkg::ADDR_WIDTH-1:0]     addr_sh;
  logic [sact_pkg::SET_W-1:0]          set_idx;

  logic [sact_pkg::SET_W-1:0]          set_r;
  logic [sact_pkg::TAG_W-1:0]          tag_r;
  logic                                second_r;
  logic                                use_fwd_r;
  sact_pkg::row_t                      fwd_row_r;

  logic                                in_fire;
  logic                                rd_en;
  logic                                do_look;
  sact_pkg::row_t                      mem_row;
  sact_pkg::row_t                      cur_row;
  sact_pkg::row_t                      new_row;
  sact_pkg::lk_res_t                   res;

  logic                                out_valid_r;
  logic                                out_hit_r;
  logic                                out_evicted_r;
  logic                                out_last_r;
  logic [sact_pkg::CNT_W-1:0]          hits_r;
  logic [sact_pkg::CNT_W-1:0]          misses_r;
  logic [sact_pkg::CNT_W-1:0]          evictions_r;

  // register decode with out-of-range values folded in
  always_comb begin
    set_eff = (int'(set_bits_r) > sact_pkg::MAX_SET_BITS) ?
              sact_pkg::SETCNT_W'(sact_pkg::MAX_SET_BITS) :
              sact_pkg::SETCNT_W'(set_bits_r);
    blk_eff = (block_bits_r == '0) ? sact_pkg::BLKB_W'(1) : block_bits_r;
    if (ways_used_r == '0) begin
      ways_eff = sact_pkg::WAYCNT_W'(1);
    end else if (int'(ways_used_r) > sact_pkg::MAX_WAYS) begin
      ways_eff = sact_pkg::WAYCNT_W'(sact_pkg::MAX_WAYS);
    end else begin
      ways_eff = sact_pkg::WAYCNT_W'(ways_used_r);
    end
    for (int i = 0; i < sact_pkg::SET_W; i++) begin
      set_mask[i] = sact_pkg::SETCNT_W'(i) < set_eff;
    end
    tag_sh  = sact_pkg::SHIFT_W'(blk_eff) + sact_pkg::SHIFT_W'(set_eff);
    addr_sh = in_address >> blk_eff;
    set_idx = addr_sh[sact_pkg::SET_W-1:0] & set_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= sact_pkg::SETB_W'(4);
      block_bits_r <= sact_pkg::BLKB_W'(4);
      ways_used_r  <= sact_pkg::WAYS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        sact_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_wdata[sact_pkg::SETB_W-1:0];
        sact_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[sact_pkg::BLKB_W-1:0];
        sact_pkg::CFG_WAYS_USED:  ways_used_r  <= cfg_wdata[sact_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign rd_en    = in_fire && (in_op != sact_pkg::OP_NONE);
  assign do_look  = (state_r == ST_LOOK) && (!out_valid_r || out_ready);

  sact_row_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (set_idx),
    .rd_row  (mem_row),
    .wr_en   (do_look),
    .wr_addr (set_r),
    .wr_row  (new_row)
  );

  // second lookup of a modify sees the row just written
  assign cur_row = use_fwd_r ? fwd_row_r : mem_row;

  sact_lookup u_lookup (
    .row_in  (cur_row),
    .tag     (tag_r),
    .ways    (ways_eff),
    .row_out (new_row),
    .res     (res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (rd_en) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (do_look && !second_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      second_r    <= 1'b0;
      use_fwd_r   <= 1'b0;
      out_valid_r <= 1'b0;
      hits_r      <= '0;
      misses_r    <= '0;
      evictions_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (rd_en) begin
        second_r  <= (in_op == sact_pkg::OP_MODIFY);
        use_fwd_r <= 1'b0;
      end else if (do_look) begin
        second_r  <= 1'b0;
        use_fwd_r <= second_r;
      end
      if (do_look) begin
        out_valid_r <= 1'b1;
        if (res.hit) begin
          hits_r <= sact_pkg::sat_inc(hits_r);
        end else begin
          misses_r <= sact_pkg::sat_inc(misses_r);
        end
        if (res.evicted) begin
          evictions_r <= sact_pkg::sat_inc(evictions_r);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      set_r <= set_idx;
      tag_r <= sact_pkg::TAG_W'(in_address >> tag_sh);
    end
    if (do_look) begin
      fwd_row_r     <= new_row;
      out_hit_r     <= res.hit;
      out_evicted_r <= res.evicted;
      out_last_r    <= !second_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_evicted        = out_evicted_r;
  assign out_last           = out_last_r;
  assign out_hit_count      = hits_r;
  assign out_miss_count     = misses_r;
  assign out_eviction_count = evictions_r;

endmodule
`default_nettype wire

### hw/rtl/sact_checker.sv
// port-level checks of the cache tracker, bound to the top level
`default_nettype none
module sact_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire                                out_hit,
  input wire                                out_evicted,
  input wire                                out_last,
  input wire [sact_pkg::CNT_W-1:0]          out_hit_count,
  input wire [sact_pkg::CNT_W-1:0]          out_miss_count,
  input wire [sact_pkg::CNT_W-1:0]          out_eviction_count
);

  // a stalled beat keeps its flags and its hit and miss totals
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_evicted) &&
      $stable(out_last) && $stable(out_hit_count) && $stable(out_miss_count))
    else $error("output beat changed while stalled");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction on one lookup");

  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_hit_count != '0)
    else $error("hit beat with zero hit total");

  a_evict_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> out_eviction_count != '0 && out_miss_count != '0)
    else $error("eviction beat without eviction and miss totals");

  // totals never go backward from one beat to the next
  a_totals_grow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> out_hit_count >= $past(out_hit_count) &&
      out_miss_count >= $past(out_miss_count) &&
      out_eviction_count >= $past(out_eviction_count))
    else $error("running total decreased");

endmodule

bind set_assoc_lru_cache_tracker sact_checker u_sact_checker (.*);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// testbench of the set-associative lru cache tracker, checked beat by beat against a tag store model
module tb;
  import sact_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int POOL_SIZE     = 16;
  localparam int NUM_LINES     = NUM_SETS * MAX_WAYS;

  typedef struct {
    logic             hit;
    logic             evicted;
    logic             last;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } lookup_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [OP_W-1:0]       in_op;
  logic [ADDR_WIDTH-1:0] in_address;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_hit;
  logic                  out_evicted;
  logic                  out_last;
  logic [CNT_W-1:0]      out_hit_count;
  logic [CNT_W-1:0]      out_miss_count;
  logic [CNT_W-1:0]      out_eviction_count;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;

  // tag store model
  logic              line_ok [NUM_LINES];
  logic [TAG_W-1:0]  line_tag_m [NUM_LINES];
  logic [RANK_W-1:0] line_age [NUM_LINES];
  logic [CNT_W-1:0]  hits_seen;
  logic [CNT_W-1:0]  misses_seen;
  logic [CNT_W-1:0]  evicts_seen;
  logic [SETB_W-1:0] reg_set_bits;
  logic [BLKB_W-1:0] reg_block_bits;
  logic [WAYS_W-1:0] reg_ways;

  lookup_result_t   pending_results[$];
  logic [63:0]      addr_pool [POOL_SIZE];
  int               error_count;
  bit               gaps_on;
  bit               stalls_on;
  int               hold_cycles;

  set_assoc_lru_cache_tracker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_evicted        (out_evicted),
    .out_last           (out_last),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic int eff_set_bits();
    return (int'(reg_set_bits) > MAX_SET_BITS) ? MAX_SET_BITS : int'(reg_set_bits);
  endfunction

  function automatic int eff_block_bits();
    return (reg_block_bits == 0) ? 1 : int'(reg_block_bits);
  endfunction

  // make way w most recent; valid ways ranked below limit age by one
  function automatic void age_ways(input int base, input int nways, input int w,
                                   input int limit);
    for (int i = 0; i < nways; i++) begin
      if (i != w && line_ok[base + i] && int'(line_age[base + i]) < limit) begin
        if (int'(line_age[base + i]) >= MAX_WAYS - 1) begin
          line_age[base + i] = RANK_W'(MAX_WAYS - 1);
        end else begin
          line_age[base + i] = line_age[base + i] + 1'b1;
        end
      end
    end
    line_age[base + w] = '0;
  endfunction

  function automatic void predict_lookup(input logic [63:0] addr, input logic is_last);
    int             s;
    int             b;
    int             nways;
    int             base;
    int             hw;
    int             w;
    logic [63:0]    set_idx;
    logic [TAG_W-1:0] t;
    lookup_result_t r;
    s = eff_set_bits();
    b = eff_block_bits();
    nways = (reg_ways == 0) ? 1 : ((int'(reg_ways) > MAX_WAYS) ? MAX_WAYS : int'(reg_ways));
    set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
    t = TAG_W'(addr >> (s + b));
    base = int'(set_idx) * MAX_WAYS;
    hw = -1;
    for (int i = 0; i < nways; i++) begin
      if (hw < 0 && line_ok[base + i] && line_tag_m[base + i] == t) hw = i;
    end
    r.hit = (hw >= 0);
    r.evicted = 1'b0;
    r.last = is_last;
    if (hw >= 0) begin
      age_ways(base, nways, hw, int'(line_age[base + hw]));
      hits_seen = bump(hits_seen);
    end else begin
      misses_seen = bump(misses_seen);
      w = -1;
      for (int i = 0; i < nways; i++) begin
        if (w < 0 && !line_ok[base + i]) w = i;
      end
      if (w < 0) begin
        // victim is the oldest way, lowest index on a tie
        w = 0;
        for (int i = 1; i < nways; i++) begin
          if (line_age[base + i] > line_age[base + w]) w = i;
        end
        r.evicted = 1'b1;
        evicts_seen = bump(evicts_seen);
      end
      line_ok[base + w] = 1'b1;
      line_tag_m[base + w] = t;
      age_ways(base, nways, w, MAX_WAYS);
    end
    r.hits = hits_seen;
    r.misses = misses_seen;
    r.evictions = evicts_seen;
    pending_results.push_back(r);
  endfunction

  // mostly addresses near earlier ones, so sets fill up, hit and evict
  function automatic logic [63:0] hot_address();
    int          s;
    int          b;
    int          k;
    int          r;
    logic [63:0] low_mask;
    logic [63:0] a;
    s = eff_set_bits();
    b = eff_block_bits();
    low_mask = (64'd1 << (s + b)) - 64'd1;
    k = $urandom_range(0, POOL_SIZE - 1);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      a = addr_pool[k] ^ ({$urandom, $urandom} & ((64'd1 << b) - 64'd1));
    end else if (r < 85) begin
      a = (addr_pool[k] & low_mask) | (64'($urandom_range(0, 11)) << (s + b));
      addr_pool[$urandom_range(0, POOL_SIZE - 1)] = a;
    end else begin
      a = {$urandom, $urandom};
      addr_pool[k] = a;
    end
    return a;
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_LOAD;
    if (r < 65) return OP_STORE;
    if (r < 96) return OP_MODIFY;
    return OP_NONE;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      error_count++;
      $display("%0t: %s expected %0h got %0h", $time, field, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin : result_check
    lookup_result_t e;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected, hit %0b last %0b",
                 $time, out_hit, out_last);
      end else begin
        e = pending_results.pop_front();
        check_field("hit", e.hit, out_hit);
        check_field("evicted", e.evicted, out_evicted);
        check_field("last", e.last, out_last);
        check_field("hit_count", e.hits, out_hit_count);
        check_field("miss_count", e.misses, out_miss_count);
        check_field("eviction_count", e.evictions, out_eviction_count);
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : receiver
    int stall_left;
    int r;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (stalls_on && $urandom_range(0, 99) < 25) begin
        r = $urandom_range(0, 99);
        stall_left = (r < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_access(input logic [OP_W-1:0] op, input logic [63:0] addr);
    int gap;
    int r;
    in_valid <= 1'b1;
    in_op <= op;
    in_address <= addr;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (op != OP_NONE) begin
      predict_lookup(addr, op != OP_MODIFY);
      if (op == OP_MODIFY) predict_lookup(addr, 1'b1);
    end
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 60) gap = (r < 92) ? $urandom_range(1, 3) : $urandom_range(6, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // an ignored op gives no beat, so allow the pipeline to empty as well
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SET_BITS:   reg_set_bits = data[SETB_W-1:0];
      CFG_BLOCK_BITS: reg_block_bits = data[BLKB_W-1:0];
      CFG_WAYS_USED:  reg_ways = data[WAYS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] sb, input logic [CFG_W-1:0] bb,
                           input logic [CFG_W-1:0] wu, input int n);
    int              sent;
    logic [OP_W-1:0] op;
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_BLOCK_BITS, bb);
    write_reg(CFG_WAYS_USED, wu);
    sent = 0;
    while (sent < n) begin
      op = pick_op();
      send_access(op, hot_address());
      if (op != OP_NONE) sent++;
      if ($urandom_range(0, 199) == 0) wait_results();
    end
  endtask

  task automatic test_defaults();
    send_access(OP_LOAD, 64'd0);
    send_access(OP_LOAD, 64'd0);
    send_access(OP_STORE, 64'hF);
    send_access(OP_MODIFY, 64'h100);
    send_access(OP_NONE, '1);
    send_access(OP_LOAD, '1);
    send_access(OP_MODIFY, '1);
    send_access(OP_STORE, 64'h8000_0000_0000_0000);
    send_access(OP_LOAD, 64'h5555_5555_5555_5555);
    send_access(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
  endtask

  task automatic test_register_extremes();
    // zero settings: one set, one offset bit, one way
    write_reg(CFG_SET_BITS, 5'd0);
    write_reg(CFG_BLOCK_BITS, 5'd0);
    write_reg(CFG_WAYS_USED, 5'd0);
    write_reg(CFG_UNUSED, 5'd31);
    send_access(OP_LOAD, 64'd0);
    send_access(OP_STORE, 64'd1);
    send_access(OP_LOAD, 64'd2);
    // out-of-range settings clamp; fill set 0 past its ways
    write_reg(CFG_SET_BITS, 5'd7);
    write_reg(CFG_BLOCK_BITS, 5'd31);
    write_reg(CFG_WAYS_USED, 5'd15);
    for (int t = 1; t <= 9; t++) send_access(OP_LOAD, 64'(t) << 37);
    send_access(OP_STORE, 64'd2 << 37);
    // shrink then regrow the ways, leaving stale ranks behind
    write_reg(CFG_WAYS_USED, 5'd2);
    send_access(OP_LOAD, 64'd3 << 37);
    write_reg(CFG_WAYS_USED, 5'd8);
    send_access(OP_MODIFY, 64'd5 << 37);
  endtask

  task automatic test_random_mix();
    run_phase(5'd1, 5'd1, 5'd1, 180);
    run_phase(5'd6, 5'd16, 5'd8, 220);
    run_phase(5'd0, 5'd0, 5'd0, 120);
    run_phase(5'd7, 5'd31, 5'd15, 200);
    run_phase(5'd2, 5'd5, 5'd4, 200);
    repeat (4) begin
      run_phase(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)),
                CFG_W'($urandom_range(0, 31)), 180);
    end
  endtask

  task automatic test_output_stall();
    gaps_on = 1'b0;
    hold_cycles = 300;
    repeat (60) send_access(($urandom_range(0, 1) != 0) ? OP_MODIFY : OP_LOAD, hot_address());
    wait_results();
    gaps_on = 1'b1;
  endtask

  task automatic test_streaming();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (150) send_access(pick_op(), hot_address());
    wait_results();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    error_count = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    hold_cycles = 0;
    reg_set_bits = SETB_W'(4);
    reg_block_bits = BLKB_W'(4);
    reg_ways = WAYS_W'(1);
    hits_seen = '0;
    misses_seen = '0;
    evicts_seen = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      line_ok[i] = 1'b0;
      line_tag_m[i] = '0;
      line_age[i] = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = {$urandom, $urandom};
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_op <= OP_LOAD;
    in_address <= '0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SET_BITS;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_register_extremes();
    test_random_mix();
    test_output_stall();
    test_streaming();

    wait_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/sact_pkg.sv
hw/rtl/sact_row_mem.sv
hw/rtl/sact_lookup.sv
hw/rtl/set_assoc_lru_cache_tracker.sv
hw/rtl/sact_checker.sv
tb/tb.sv
